### sv/deq_pkg.sv
// Shared types and codes for the double-ended queue.
`timescale 1ns / 1ps
package deq_pkg;

  localparam int WordW = 32;

  // Request codes
  localparam logic [1:0] REQ_PUSH_REAR  = 2'd0;
  localparam logic [1:0] REQ_PUSH_FRONT = 2'd1;
  localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
  localparam logic [1:0] REQ_POP_REAR   = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  localparam logic signed [WordW-1:0] NO_VALUE = '1;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [WordW-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [WordW-1:0] pop_value;
    logic [1:0]              status;
    logic                    is_empty;
    logic                    is_full;
  } rsp_t;

  // What every cell of a chain does in a cycle
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SHIFT_IN,   // head push: everything moves one cell toward the tail
    OP_SHIFT_OUT,  // head pop: everything moves one cell toward the head
    OP_APPEND,     // tail push: first free cell takes the word
    OP_TRIM        // tail pop: last used cell goes free
  } cell_op_t;

  typedef struct packed {
    cell_op_t                op;
    logic signed [WordW-1:0] word;
  } cell_cmd_t;

  typedef struct packed {
    logic signed [WordW-1:0] head_word;
    logic                    empty;
    logic                    second_used;
    logic                    near_full;
    logic                    full;
  } chain_stat_t;

endpackage

### sv/deq_cell.sv
// One storage cell of a deque chain: a word and its in-use flag.
`timescale 1ns / 1ps
module deq_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  deq_pkg::cell_cmd_t                  cmd,
  input  logic signed [deq_pkg::WordW-1:0]    left_word,
  input  logic                                left_used,
  input  logic signed [deq_pkg::WordW-1:0]    right_word,
  input  logic                                right_used,
  output logic signed [deq_pkg::WordW-1:0]    word_r,
  output logic                                used_r
);
  import deq_pkg::*;

  logic signed [WordW-1:0] word_nxt;
  logic                    used_nxt;

  always_comb begin
    word_nxt = word_r;
    used_nxt = used_r;
    unique case (cmd.op)
      OP_SHIFT_IN: begin
        word_nxt = left_word;
        used_nxt = left_used;
      end
      OP_SHIFT_OUT: begin
        word_nxt = right_word;
        used_nxt = right_used;
      end
      OP_APPEND: begin
        if (left_used && !used_r) begin
          word_nxt = cmd.word;
          used_nxt = 1'b1;
        end
      end
      OP_TRIM: begin
        if (used_r && !right_used) used_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) used_r <= 1'b0;
    else        used_r <= used_nxt;
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

endmodule

### sv/deq_chain.sv
// Row of deque cells, head at cell 0, occupied cells packed toward the head.
`timescale 1ns / 1ps
module deq_chain #(
  parameter int DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  deq_pkg::cell_cmd_t   cmd,
  output deq_pkg::chain_stat_t stat
);
  import deq_pkg::*;

  logic signed [WordW-1:0] word [DEPTH];
  logic [DEPTH-1:0]        used;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WordW-1:0] lw, rw;
    logic                    lu, ru;

    if (i == 0) begin : g_head
      assign lw = cmd.word;   // head push enters here
      assign lu = 1'b1;
    end else begin : g_mid_l
      assign lw = word[i-1];
      assign lu = used[i-1];
    end

    if (i == DEPTH-1) begin : g_tail
      assign rw = '0;
      assign ru = 1'b0;
    end else begin : g_mid_r
      assign rw = word[i+1];
      assign ru = used[i+1];
    end

    deq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .left_word  (lw),
      .left_used  (lu),
      .right_word (rw),
      .right_used (ru),
      .word_r     (word[i]),
      .used_r     (used[i])
    );
  end

  assign stat.head_word   = word[0];
  assign stat.empty       = !used[0];
  assign stat.second_used = used[1];
  assign stat.near_full   = used[DEPTH-2];
  assign stat.full        = used[DEPTH-1];

endmodule

### sv/double_ended_queue_top.sv
// Top level of the double-ended queue: two mirrored cell chains and the result register.
//
//   channel | ports                          | beat
//   --------+--------------------------------+-----------------------------------
//   request | in_valid, in_ready, in_data    | req_type, push_value
//   result  | out_valid, out_ready, out_data | pop_value, status, is_empty, is_full
//
// One request per cycle unless a result stalls; its result is registered and
// shows in the cycle after acceptance. Both chains keep a full copy of the
// queue: chain A has the front at cell 0, chain B has the rear at cell 0, so
// every pop reads a fixed cell and every push is a shift or a local append.
// Reset empties both chains at once; no clearing pass.
// A stalled result holds its register; a new request is taken in the same
// cycle that the pending result leaves.
`timescale 1ns / 1ps
module double_ended_queue_top #(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  deq_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output deq_pkg::rsp_t out_data
);
  import deq_pkg::*;

  cell_cmd_t   cmd_a, cmd_b;
  chain_stat_t stat_a, stat_b;

  rsp_t rsp_nxt, rsp_r;
  logic out_valid_r, out_valid_nxt;
  logic take;
  logic is_push, push_ok, pop_ok;

  assign in_ready = !out_valid_r || out_ready;
  assign take     = in_valid && in_ready;

  assign is_push = !in_data.req_type[1];
  assign push_ok = is_push && !stat_a.full;
  assign pop_ok  = !is_push && !stat_a.empty;

  // Chain commands: the end being worked on shifts, the other end
  // appends or trims.
  always_comb begin
    cmd_a.op   = OP_HOLD;
    cmd_b.op   = OP_HOLD;
    cmd_a.word = in_data.push_value;
    cmd_b.word = in_data.push_value;
    if (take && (push_ok || pop_ok)) begin
      unique case (in_data.req_type)
        REQ_PUSH_REAR: begin
          cmd_a.op = OP_APPEND;
          cmd_b.op = OP_SHIFT_IN;
        end
        REQ_PUSH_FRONT: begin
          cmd_a.op = OP_SHIFT_IN;
          cmd_b.op = OP_APPEND;
        end
        REQ_POP_FRONT: begin
          cmd_a.op = OP_SHIFT_OUT;
          cmd_b.op = OP_TRIM;
        end
        REQ_POP_REAR: begin
          cmd_a.op = OP_TRIM;
          cmd_b.op = OP_SHIFT_OUT;
        end
        default: ;
      endcase
    end
  end

  deq_chain #(.DEPTH(DEPTH)) u_chain_a (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd_a),
    .stat  (stat_a)
  );

  deq_chain #(.DEPTH(DEPTH)) u_chain_b (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd_b),
    .stat  (stat_b)
  );

  // Result for the request being taken; flags reflect occupancy after it.
  always_comb begin
    rsp_nxt.pop_value = NO_VALUE;
    rsp_nxt.status    = ST_OK;
    rsp_nxt.is_empty  = stat_a.empty;
    rsp_nxt.is_full   = stat_a.full;
    if (is_push) begin
      if (push_ok) begin
        rsp_nxt.is_empty = 1'b0;
        rsp_nxt.is_full  = stat_a.near_full;
      end else begin
        rsp_nxt.status = ST_OVERFLOW;
      end
    end else begin
      if (pop_ok) begin
        rsp_nxt.pop_value = (in_data.req_type == REQ_POP_FRONT) ? stat_a.head_word
                                                                : stat_b.head_word;
        rsp_nxt.is_empty  = !stat_a.second_used;
        rsp_nxt.is_full   = 1'b0;
      end else begin
        rsp_nxt.status = ST_UNDERFLOW;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take)           out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (take) rsp_r <= rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = rsp_r;

  // The two chains must always agree on occupancy.
  a_chains_agree: assert property (@(posedge clk) disable iff (!rst_n)
    (stat_a.empty == stat_b.empty) && (stat_a.full == stat_b.full))
    else $error("chain occupancy mismatch");

  // With one word held, both chains hold it at the head.
  a_single_same: assert property (@(posedge clk) disable iff (!rst_n)
    (!stat_a.empty && !stat_a.second_used) |-> (stat_a.head_word == stat_b.head_word))
    else $error("single held word differs between chains");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && rsp_r.status == ST_OVERFLOW) |-> rsp_r.is_full)
    else $error("overflow reported while not full");

  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && rsp_r.status == ST_UNDERFLOW) |->
      (rsp_r.is_empty && rsp_r.pop_value == NO_VALUE))
    else $error("underflow result malformed");

  a_pop_front_word: assert property (@(posedge clk) disable iff (!rst_n)
    (take && pop_ok && in_data.req_type == REQ_POP_FRONT) |=>
      (rsp_r.pop_value == $past(stat_a.head_word)))
    else $error("front pop returned wrong word");

endmodule
